// ===== design/svpwm_pkg.sv =====
// Shared types, constants and table functions for the SVPWM duty generator.
// Used by the front, queue, back and top level modules; has no dependencies.
`timescale 1ns / 1ps

package svpwm_pkg;

  // Active-vector time width after the sector stage, and divider widths.
  localparam int T_W = 32;
  localparam int Q_W = 16;
  localparam int R_W = T_W + Q_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  // Half of sqrt3 scaled by 2^16; twice this value is the sector test slope.
  localparam logic signed [17:0] SQRT3_HALF = 18'sd56756;
  localparam logic [15:0] FULL_PERIOD = 16'd32768;

  typedef enum logic [1:0] {
    CFG_ZERO_OFFSET   = 2'd0,
    CFG_POLE_PAIRS    = 2'd1,
    CFG_VOLTAGE_SCALE = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_ACTIVE  = 2'd0,
    KIND_OFFLINE = 2'd1,
    KIND_ZERO    = 2'd2
  } item_kind_t;

  // One classified item handed from the front to the back.
  typedef struct packed {
    item_kind_t            kind;
    logic [2:0]            sector;
    logic signed [T_W-1:0] t1;
    logic signed [T_W-1:0] t2;
  } queue_item_t;

  // Payload of one back-end pipeline stage.
  typedef struct packed {
    item_kind_t            kind;
    logic [2:0]            sector;
    logic                  overmod;
    logic signed [T_W-1:0] t1;
    logic signed [T_W-1:0] t2;
    logic signed [T_W:0]   t3_half;
    logic [T_W-1:0]        divisor;
    logic [R_W-1:0]        rem1;
    logic [R_W-1:0]        rem2;
    logic [Q_W-1:0]        quo1;
    logic [Q_W-1:0]        quo2;
  } back_stage_t;

  // Sector number from the three sign tests; the zero vector gives 0.
  function automatic logic [2:0] sector_of_code(input logic [2:0] code);
    logic [2:0] s;
    unique case (code)
      3'd1:    s = 3'd2;
      3'd2:    s = 3'd6;
      3'd3:    s = 3'd1;
      3'd4:    s = 3'd4;
      3'd5:    s = 3'd3;
      3'd6:    s = 3'd5;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

  // Phases switched on by basic vector idx; bit 0 is phase A.
  function automatic logic [2:0] vector_on(input logic [2:0] idx);
    logic [2:0] m;
    unique case (idx)
      3'd0:    m = 3'b001;
      3'd1:    m = 3'b011;
      3'd2:    m = 3'b010;
      3'd3:    m = 3'b110;
      3'd4:    m = 3'b100;
      3'd5:    m = 3'b101;
      default: m = 3'b000;
    endcase
    return m;
  endfunction

  // alpha * sin(idx * 60 deg) * 2^16, from the precomputed alpha * 56756.
  function automatic logic signed [47:0] sin_term(input logic [2:0] idx,
                                                  input logic signed [45:0] a56);
    logic signed [47:0] v;
    unique case (idx)
      3'd1, 3'd2: v = 48'(a56);
      3'd4, 3'd5: v = -48'(a56);
      default:    v = '0;
    endcase
    return v;
  endfunction

  // beta * cos(idx * 60 deg) * 2^16, all shifts.
  function automatic logic signed [47:0] cos_term(input logic [2:0] idx,
                                                  input logic signed [27:0] beta);
    logic signed [47:0] b;
    logic signed [47:0] v;
    b = 48'(beta);
    unique case (idx)
      3'd0:    v = b <<< 16;
      3'd1:    v = b <<< 15;
      3'd2:    v = -(b <<< 15);
      3'd3:    v = -(b <<< 16);
      3'd4:    v = -(b <<< 15);
      3'd5:    v = b <<< 15;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/svpwm_front.sv =====
// Front pipeline: electrical angle, sine/cosine, inverse Park, sector and times.
// Depends on svpwm_pkg; feeds classified items into svpwm_queue.
`timescale 1ns / 1ps

module svpwm_front
  import svpwm_pkg::*;
#(
  parameter int ANGLE_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [11:0]        mech_angle,
  input  logic signed [15:0] volt_d,
  input  logic signed [15:0] volt_q,
  input  logic               sensor_online,
  input  logic [11:0]        zero_offset,
  input  logic [5:0]         pole_pairs,
  input  logic [15:0]        voltage_scale,
  input  logic               queue_full,
  output logic               push,
  output queue_item_t        push_item
);

  logic [11:1] vld;
  logic [11:1] online;
  logic        adv;

  // The whole front moves together unless its last item cannot enter the queue.
  assign adv      = !(vld[11] && queue_full);
  assign in_ready = adv;

  // Stage 1: angle difference times pole pairs, voltage scaling products.
  logic [ANGLE_BITS-1:0]   diff_c;
  logic [ANGLE_BITS+5:0]   elec_prod;
  logic [ANGLE_BITS-1:0]   elec1;
  logic signed [32:0]      vdp1, vqp1;

  assign diff_c    = ANGLE_BITS'(mech_angle) - ANGLE_BITS'(zero_offset);
  assign elec_prod = diff_c * pole_pairs;

  // Stage 2: quarter-wave arguments and their squares.
  logic [15:0] ph_s, ph_c;
  logic [16:0] zs_c, zc_c;
  logic [33:0] zs_sq, zc_sq;
  logic [16:0] zs2, zc2, z2s2, z2c2;
  logic        negs2, negc2;
  logic signed [23:0] vdn2, vqn2;

  assign ph_s  = 16'(elec1) << (16 - ANGLE_BITS);
  assign ph_c  = ph_s + 16'h4000;
  assign zs_c  = ph_s[14] ? 17'd32768 - {2'b00, ph_s[13:0], 1'b0} : {2'b00, ph_s[13:0], 1'b0};
  assign zc_c  = ph_c[14] ? 17'd32768 - {2'b00, ph_c[13:0], 1'b0} : {2'b00, ph_c[13:0], 1'b0};
  assign zs_sq = zs_c * zs_c;
  assign zc_sq = zc_c * zc_c;

  // Stages 3 to 5: Horner steps of the odd polynomial, one multiply each.
  logic [32:0] ps3, pc3, ps4, pc4, ps5, pc5;
  logic [15:0] ts3, tc3, ts4, tc4, ts5, tc5;
  logic [16:0] zs3, zc3, zs4, zc4, zs5, zc5, z2s3, z2c3, z2s4, z2c4;
  logic        negs3, negc3, negs4, negc4, negs5, negc5;
  logic signed [23:0] vdn3, vqn3, vdn4, vqn4, vdn5, vqn5;

  assign ps3 = z2s2 * 16'd153;
  assign pc3 = z2c2 * 16'd153;
  assign ps4 = z2s3 * ts3;
  assign pc4 = z2c3 * tc3;
  assign ps5 = z2s4 * ts4;
  assign pc5 = z2c4 * tc4;

  // Stage 6: final multiply by z and the quadrant sign.
  logic [32:0] ps6, pc6;
  logic signed [17:0] sn6, cs6;
  logic signed [23:0] vdn6, vqn6;

  assign ps6 = zs5 * ts5;
  assign pc6 = zc5 * tc5;

  // Stage 7: inverse Park products.
  logic signed [41:0] p_dc7, p_qs7, p_ds7, p_qc7;

  // Stage 8: alpha and beta.
  logic signed [42:0] alpha_w, beta_w;
  logic signed [27:0] alpha8, beta8;

  assign alpha_w = 43'(p_dc7) - 43'(p_qs7);
  assign beta_w  = 43'(p_ds7) + 43'(p_qc7);

  // Stage 9: alpha times half of sqrt3.
  logic signed [45:0] a56_9;
  logic signed [27:0] beta9;

  // Stage 10: sector from the sign tests.
  logic signed [47:0] b16_c, a2_c, x1_c, x2_c;
  logic [2:0]         code_c;
  logic signed [45:0] a56_10;
  logic signed [27:0] beta10;
  logic [2:0]         sector10;

  assign b16_c  = 48'(beta9) <<< 16;
  assign a2_c   = 48'(a56_9) <<< 1;
  assign x1_c   = a2_c - b16_c;
  assign x2_c   = -a2_c - b16_c;
  assign code_c = {(x2_c > 0), (x1_c > 0), (beta9 > 0)};

  // Stage 11: the two active-vector times for the sector.
  logic [2:0]         idx_j, idx_m;
  logic signed [47:0] t1_w, t2_w;
  item_kind_t         kind_c;
  queue_item_t        item11;

  assign idx_j  = (sector10 == 3'd6) ? 3'd0 : sector10;
  assign idx_m  = (sector10 == 3'd0) ? 3'd0 : sector10 - 3'd1;
  assign t1_w   = sin_term(idx_j, a56_10) - cos_term(idx_j, beta10);
  assign t2_w   = cos_term(idx_m, beta10) - sin_term(idx_m, a56_10);

  always_comb begin
    if (!online[10]) begin
      kind_c = KIND_OFFLINE;
    end else if (sector10 == 3'd0) begin
      kind_c = KIND_ZERO;
    end else begin
      kind_c = KIND_ACTIVE;
    end
  end

  // Valid and sensor flags move with the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[10:1], in_valid};
    end
  end

  // Payload registers of all stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      online <= {online[10:1], sensor_online};
      elec1  <= elec_prod[ANGLE_BITS-1:0];
      vdp1   <= volt_d * $signed({1'b0, voltage_scale});
      vqp1   <= volt_q * $signed({1'b0, voltage_scale});

      zs2   <= zs_c;
      zc2   <= zc_c;
      z2s2  <= zs_sq[31:15];
      z2c2  <= zc_sq[31:15];
      negs2 <= ph_s[15];
      negc2 <= ph_c[15];
      vdn2  <= vdp1[32:9];
      vqn2  <= vqp1[32:9];

      ts3 <= 16'd2611 - 16'(ps3 >> 15);
      tc3 <= 16'd2611 - 16'(pc3 >> 15);
      zs3 <= zs2;   zc3 <= zc2;   z2s3 <= z2s2;  z2c3 <= z2c2;
      negs3 <= negs2; negc3 <= negc2; vdn3 <= vdn2; vqn3 <= vqn2;

      ts4 <= 16'd21167 - 16'(ps4 >> 15);
      tc4 <= 16'd21167 - 16'(pc4 >> 15);
      zs4 <= zs3;   zc4 <= zc3;   z2s4 <= z2s3;  z2c4 <= z2c3;
      negs4 <= negs3; negc4 <= negc3; vdn4 <= vdn3; vqn4 <= vqn3;

      ts5 <= 16'd51472 - 16'(ps5 >> 15);
      tc5 <= 16'd51472 - 16'(pc5 >> 15);
      zs5 <= zs4;   zc5 <= zc4;
      negs5 <= negs4; negc5 <= negc4; vdn5 <= vdn4; vqn5 <= vqn4;

      sn6  <= negs5 ? -$signed({1'b0, ps6[31:15]}) : $signed({1'b0, ps6[31:15]});
      cs6  <= negc5 ? -$signed({1'b0, pc6[31:15]}) : $signed({1'b0, pc6[31:15]});
      vdn6 <= vdn5;
      vqn6 <= vqn5;

      p_dc7 <= vdn6 * cs6;
      p_qs7 <= vqn6 * sn6;
      p_ds7 <= vdn6 * sn6;
      p_qc7 <= vqn6 * cs6;

      alpha8 <= alpha_w[42:15];
      beta8  <= beta_w[42:15];

      a56_9 <= alpha8 * SQRT3_HALF;
      beta9 <= beta8;

      a56_10   <= a56_9;
      beta10   <= beta9;
      sector10 <= sector_of_code(code_c);

      item11.kind   <= kind_c;
      item11.sector <= sector10;
      item11.t1     <= t1_w[47:16];
      item11.t2     <= t2_w[47:16];
    end
  end

  assign push      = vld[11] && !queue_full;
  assign push_item = item11;

endmodule

// ===== design/svpwm_queue.sv =====
// Short item queue between the front and back pipelines.
// Depends on svpwm_pkg for the item type and depth.
`timescale 1ns / 1ps

module svpwm_queue
  import svpwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  queue_item_t push_item,
  output logic        full,
  input  logic        pop,
  output logic        not_empty,
  output queue_item_t pop_item
);

  queue_item_t          entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]    count;

  assign full      = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QUEUE_AW + 1)'(push) - (QUEUE_AW + 1)'(pop);
    end
  end

  // Item storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== design/svpwm_back.sv =====
// Back pipeline: overmodulation check, rescale divider and duty clamp.
// Depends on svpwm_pkg; pulls items from svpwm_queue and drives the output register.
`timescale 1ns / 1ps

module svpwm_back
  import svpwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        not_empty,
  input  queue_item_t pop_item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] duty_a,
  output logic [15:0] duty_b,
  output logic [15:0] duty_c,
  output logic [2:0]  sector_num,
  output logic        update_duties,
  output logic        overmodulated
);

  back_stage_t st  [Q_W+1];
  logic        vld [Q_W+1];
  logic        adv;

  assign adv = !out_valid || out_ready;
  assign pop = not_empty && adv;

  // Entry stage: sum of the active times and the overmodulation decision.
  logic signed [T_W:0]   tsum_c;
  logic signed [T_W+1:0] t3_c;
  logic                  om_c;

  assign tsum_c = (T_W + 1)'(pop_item.t1) + (T_W + 1)'(pop_item.t2);
  assign om_c   = (pop_item.kind == KIND_ACTIVE) && (tsum_c > $signed({1'b0, FULL_PERIOD}));
  assign t3_c   = om_c ? '0 : (T_W + 2)'($signed({1'b0, FULL_PERIOD})) - (T_W + 2)'(tsum_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0].kind    <= pop_item.kind;
      st[0].sector  <= pop_item.sector;
      st[0].overmod <= om_c;
      st[0].t1      <= pop_item.t1;
      st[0].t2      <= pop_item.t2;
      st[0].t3_half <= t3_c[T_W+1:1];
      st[0].divisor <= tsum_c[T_W-1:0];
      st[0].rem1    <= R_W'(pop_item.t1[T_W-2:0]) << (Q_W - 1);
      st[0].rem2    <= R_W'(pop_item.t2[T_W-2:0]) << (Q_W - 1);
      st[0].quo1    <= '0;
      st[0].quo2    <= '0;
    end
  end

  // Restoring divider for overmodulated items, one quotient bit per stage for both times.
  for (genvar s = 1; s <= Q_W; s++) begin : g_div
    localparam int BIT = Q_W - s;
    back_stage_t    nxt;
    logic [R_W-1:0] dshift;

    assign dshift = R_W'(st[s-1].divisor) << BIT;

    always_comb begin
      nxt = st[s-1];
      if (st[s-1].overmod) begin
        if (st[s-1].rem1 >= dshift) begin
          nxt.rem1      = st[s-1].rem1 - dshift;
          nxt.quo1[BIT] = 1'b1;
        end
        if (st[s-1].rem2 >= dshift) begin
          nxt.rem2      = st[s-1].rem2 - dshift;
          nxt.quo2[BIT] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (adv) begin
        vld[s] <= vld[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[s] <= nxt;
      end
    end
  end

  // Duty stage: sum the times switched onto each phase and clamp.
  back_stage_t           fin;
  logic signed [T_W-1:0] e1, e2;
  logic [2:0]            on1, on2, j_idx;
  logic signed [T_W+2:0] dsum [3];
  logic [15:0]           dclamp [3];

  assign fin   = st[Q_W];
  assign e1    = fin.overmod ? T_W'($signed({1'b0, fin.quo1})) : fin.t1;
  assign e2    = fin.overmod ? T_W'($signed({1'b0, fin.quo2})) : fin.t2;
  assign j_idx = (fin.sector == 3'd6) ? 3'd0 : fin.sector;
  assign on1   = vector_on(fin.sector - 3'd1);
  assign on2   = vector_on(j_idx);

  for (genvar p = 0; p < 3; p++) begin : g_phase
    assign dsum[p] = (on1[p] ? (T_W + 3)'(e1) : '0) + (on2[p] ? (T_W + 3)'(e2) : '0)
                   + (T_W + 3)'(fin.t3_half);
    always_comb begin
      if (fin.kind != KIND_ACTIVE || dsum[p] < 0) begin
        dclamp[p] = '0;
      end else if (dsum[p] > $signed({1'b0, FULL_PERIOD})) begin
        dclamp[p] = FULL_PERIOD;
      end else begin
        dclamp[p] = dsum[p][15:0];
      end
    end
  end

  // Output register; holds while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      duty_a        <= dclamp[0];
      duty_b        <= dclamp[1];
      duty_c        <= dclamp[2];
      sector_num    <= (fin.kind == KIND_ACTIVE) ? fin.sector : 3'd0;
      update_duties <= (fin.kind != KIND_ZERO);
      overmodulated <= fin.overmod;
    end
  end

endmodule

// ===== design/svpwm_duty_generator.sv =====
// Top level of the SVPWM duty generator: configuration registers and stream ports.
// Depends on svpwm_pkg, svpwm_front, svpwm_queue and svpwm_back.
//
// Usage: each input item carries a mechanical angle, d/q voltage commands
// and the sensor-online flag (in s_axis_tuser). Each accepted item gives
// exactly one result item on the master stream: three phase duties
// (32768 is full period), the sector, an update flag and an overmodulation
// flag. Configuration registers (zero offset, pole pairs, voltage scale)
// are written through cfg_we/cfg_index/cfg_data while the block is idle.
// Throughput is one item per cycle while the receiver does not stall; every
// stage of the front and back pipelines is a register, and the 16-stage
// rescale divider is pipelined. With no stall, an item passes through the
// 11 front stages, the queue, one entry stage, 16 divider stages and the
// output register. When the receiver stalls, the back pipeline holds, the
// 4-item queue fills, and then the front holds and drops s_axis_tready.
// Reset clears the pipeline valid flags, empties the queue and loads the
// configuration defaults (offset 0, 11 pole pairs, scale 4730).
`timescale 1ns / 1ps

module svpwm_duty_generator
  import svpwm_pkg::*;
#(
  parameter int ANGLE_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // mech_angle[11:0], volt_d[27:12], volt_q[43:28], zero fill [47:44]
  input  logic [47:0] s_axis_tdata,
  // sensor_online[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // duty_a[15:0], duty_b[31:16], duty_c[47:32], sector_num[50:48],
  // update_duties[51], overmodulated[52], zero fill [55:53]
  output logic [55:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [11:0] zero_offset;
  logic [5:0]  pole_pairs;
  logic [15:0] voltage_scale;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_offset   <= 12'd0;
      pole_pairs    <= 6'd11;
      voltage_scale <= 16'd4730;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_ZERO_OFFSET:   zero_offset   <= cfg_data[11:0];
        CFG_POLE_PAIRS:    pole_pairs    <= cfg_data[5:0];
        CFG_VOLTAGE_SCALE: voltage_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  logic        push, queue_full, pop, not_empty;
  queue_item_t push_item, pop_item;

  svpwm_front #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .mech_angle    (s_axis_tdata[11:0]),
    .volt_d        ($signed(s_axis_tdata[27:12])),
    .volt_q        ($signed(s_axis_tdata[43:28])),
    .sensor_online (s_axis_tuser[0]),
    .zero_offset   (zero_offset),
    .pole_pairs    (pole_pairs),
    .voltage_scale (voltage_scale),
    .queue_full    (queue_full),
    .push          (push),
    .push_item     (push_item)
  );

  svpwm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_item  (pop_item)
  );

  logic [15:0] duty_a, duty_b, duty_c;
  logic [2:0]  sector_num;
  logic        update_duties, overmodulated;

  svpwm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .not_empty     (not_empty),
    .pop_item      (pop_item),
    .pop           (pop),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .duty_a        (duty_a),
    .duty_b        (duty_b),
    .duty_c        (duty_c),
    .sector_num    (sector_num),
    .update_duties (update_duties),
    .overmodulated (overmodulated)
  );

  assign m_axis_tdata = {3'b000, overmodulated, update_duties, sector_num,
                         duty_c, duty_b, duty_a};

endmodule
